@@ hw/rtl/vl2n_pkg.sv @@
// vl2n_pkg: shared constants, controller states and the command/status
// structs between the controller and the datapath of the l2 norm block
// depends on nothing

package vl2n_pkg;

    // field and register widths
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int SKIP_W      = 16;
    localparam int INDEX_BITS  = 16;
    localparam int CMP_W       = (INDEX_BITS > SKIP_W) ? INDEX_BITS : SKIP_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SKIP_W;

    // square root: one result bit per step
    localparam int SQRT_STEPS  = ACC_W / 2;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLEX_MODE = 1'd1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RE,
        ST_ADD_RE,
        ST_MUL_IM,
        ST_ADD_IM,
        ST_LOAD,
        ST_SQRT,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input item
        logic mul;       // square one part into the product register
        logic sel_im;    // square the imaginary part
        logic add;       // add the product into the accumulator
        logic sqrt_load; // move the sum into the root unit, clear the sum
        logic sqrt_step; // one root iteration
        logic out_load;  // place the root in the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;         // captured item closes the vector
        logic complex_mode; // two parts per item
        logic sqrt_done;    // final root iteration this cycle
        logic out_busy;     // output register holds an item not taken now
    } t_status;

endpackage

@@ hw/rtl/vl2n_in_if.sv @@
// vl2n_in_if: input item channel of the l2 norm block, valid/ready
// depends on nothing

interface vl2n_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
    logic               last;

    modport source (output valid, output real_part, output imag_part, output last,
                    input ready);
    modport sink   (input valid, input real_part, input imag_part, input last,
                    output ready);
endinterface

@@ hw/rtl/vl2n_out_if.sv @@
// vl2n_out_if: result item channel of the l2 norm block, valid/ready
// depends on nothing

interface vl2n_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] norm;
    logic        saturated;

    modport source (output valid, output norm, output saturated, input ready);
    modport sink   (input valid, input norm, input saturated, output ready);
endinterface

@@ hw/rtl/vl2n_ctrl.sv @@
// vl2n_ctrl: sequencing state machine of the l2 norm block
// depends on vl2n_pkg

module vl2n_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vl2n_pkg::t_status i_status,
    output vl2n_pkg::t_cmd   o_cmd
);

    vl2n_pkg::t_state r_state;
    vl2n_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vl2n_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vl2n_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = vl2n_pkg::ST_MUL_RE;
            end
            vl2n_pkg::ST_MUL_RE: n_state = vl2n_pkg::ST_ADD_RE;
            vl2n_pkg::ST_ADD_RE: begin
                if (i_status.complex_mode) n_state = vl2n_pkg::ST_MUL_IM;
                else if (i_status.last)    n_state = vl2n_pkg::ST_LOAD;
                else                       n_state = vl2n_pkg::ST_IDLE;
            end
            vl2n_pkg::ST_MUL_IM: n_state = vl2n_pkg::ST_ADD_IM;
            vl2n_pkg::ST_ADD_IM: begin
                if (i_status.last) n_state = vl2n_pkg::ST_LOAD;
                else               n_state = vl2n_pkg::ST_IDLE;
            end
            vl2n_pkg::ST_LOAD: n_state = vl2n_pkg::ST_SQRT;
            vl2n_pkg::ST_SQRT: begin
                if (i_status.sqrt_done) n_state = vl2n_pkg::ST_DONE;
            end
            vl2n_pkg::ST_DONE: begin
                if (!i_status.out_busy) n_state = vl2n_pkg::ST_IDLE;
            end
            default: n_state = vl2n_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            vl2n_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            vl2n_pkg::ST_MUL_RE: o_cmd.mul = 1'b1;
            vl2n_pkg::ST_ADD_RE: o_cmd.add = 1'b1;
            vl2n_pkg::ST_MUL_IM: begin
                o_cmd.mul    = 1'b1;
                o_cmd.sel_im = 1'b1;
            end
            vl2n_pkg::ST_ADD_IM: o_cmd.add = 1'b1;
            vl2n_pkg::ST_LOAD:   o_cmd.sqrt_load = 1'b1;
            vl2n_pkg::ST_SQRT:   o_cmd.sqrt_step = 1'b1;
            vl2n_pkg::ST_DONE:   o_cmd.out_load  = !i_status.out_busy;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/vl2n_dp.sv @@
// vl2n_dp: datapath of the l2 norm block: config registers, element index,
// squaring multiplier, saturating accumulator, bitwise root unit, output register
// depends on vl2n_pkg

module vl2n_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [vl2n_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [vl2n_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input item payload
    input  logic signed [vl2n_pkg::DATA_W-1:0]   i_real_part,
    input  logic signed [vl2n_pkg::DATA_W-1:0]   i_imag_part,
    input  logic                                 i_last,
    // result item
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [vl2n_pkg::DATA_W-1:0]          o_norm,
    output logic                                 o_saturated,
    // controller
    input  vl2n_pkg::t_cmd                       i_cmd,
    output vl2n_pkg::t_status                    o_status
);

    localparam logic [vl2n_pkg::INDEX_BITS-1:0] INDEX_LIMIT = '1;
    localparam logic [vl2n_pkg::ACC_W-1:0] SQRT_BIT0 =
        vl2n_pkg::ACC_W'(1) << (vl2n_pkg::ACC_W - 2);

    logic [vl2n_pkg::SKIP_W-1:0]      r_skip_count;
    logic                             r_complex_mode;
    logic [vl2n_pkg::INDEX_BITS-1:0]  r_index;
    logic [vl2n_pkg::DATA_W-1:0]      r_re;
    logic [vl2n_pkg::DATA_W-1:0]      r_im;
    logic                             r_last;
    logic                             r_use;
    logic [vl2n_pkg::ACC_W-1:0]       r_product;
    logic [vl2n_pkg::ACC_W-1:0]       r_acc;
    logic                             r_ovf;
    logic [vl2n_pkg::ACC_W-1:0]       r_num;
    logic [vl2n_pkg::ACC_W-1:0]       r_res;
    logic [vl2n_pkg::ACC_W-1:0]       r_bit;
    logic [vl2n_pkg::SQRT_CNT_W-1:0]  r_cnt;
    logic                             r_sat;
    logic                             r_out_valid;
    logic [vl2n_pkg::DATA_W-1:0]      r_norm;
    logic                             r_out_sat;

    logic                             w_use;
    logic [vl2n_pkg::DATA_W-1:0]      w_opnd;
    logic [vl2n_pkg::DATA_W-1:0]      w_mag;
    logic [vl2n_pkg::ACC_W:0]         w_sum;
    logic [vl2n_pkg::ACC_W-1:0]       w_trial;
    logic                             w_fits;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count   <= '0;
            r_complex_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vl2n_pkg::REG_SKIP_COUNT:   r_skip_count   <= i_cfg_data;
                vl2n_pkg::REG_COMPLEX_MODE: r_complex_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // element position against the skip count
    assign w_use = vl2n_pkg::CMP_W'(r_index) >= vl2n_pkg::CMP_W'(r_skip_count);

    // element index, stops at its limit, back to zero after a last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (i_cmd.capture) begin
            if (i_last)                    r_index <= '0;
            else if (r_index != INDEX_LIMIT) r_index <= r_index + 1'b1;
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_re   <= i_real_part;
            r_im   <= i_imag_part;
            r_last <= i_last;
            r_use  <= w_use;
        end
    end

    // magnitude of the selected part, then its exact square
    assign w_opnd = i_cmd.sel_im ? r_im : r_re;
    assign w_mag  = w_opnd[vl2n_pkg::DATA_W-1] ? (vl2n_pkg::DATA_W'(0) - w_opnd) : w_opnd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_product <= vl2n_pkg::ACC_W'(w_mag) * vl2n_pkg::ACC_W'(w_mag);
        end
    end

    // saturating accumulator, cleared when the root unit takes the sum
    assign w_sum = {1'b0, r_acc} + {1'b0, r_product};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.sqrt_load) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.add && r_use) begin
            if (w_sum[vl2n_pkg::ACC_W]) begin
                r_acc <= '1;
                r_ovf <= 1'b1;
            end else begin
                r_acc <= w_sum[vl2n_pkg::ACC_W-1:0];
            end
        end
    end

    // root unit: one result bit per step
    assign w_trial = r_res + r_bit;
    assign w_fits  = r_num >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_num <= r_acc;
            r_res <= '0;
            r_bit <= SQRT_BIT0;
            r_cnt <= '0;
            r_sat <= r_ovf;
        end else if (i_cmd.sqrt_step) begin
            if (w_fits) begin
                r_num <= r_num - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output register, freed when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_norm    <= r_res[vl2n_pkg::DATA_W-1:0];
            r_out_sat <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_norm      = r_norm;
    assign o_saturated = r_out_sat;

    // status to the controller
    assign o_status.last         = r_last;
    assign o_status.complex_mode = r_complex_mode;
    assign o_status.sqrt_done    = i_cmd.sqrt_step &&
                                   (r_cnt == vl2n_pkg::SQRT_CNT_W'(vl2n_pkg::SQRT_STEPS - 1));
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

endmodule

@@ hw/rtl/vector_l2_norm.sv @@
// vector_l2_norm: top level of the streamed euclidean norm block
// depends on vl2n_pkg, vl2n_in_if, vl2n_out_if, vl2n_ctrl, vl2n_dp
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  i_in     | in  | valid / ready       | real_part, imag_part (Q16.16), last
//  o_out    | out | valid / ready       | norm (Q16.16), saturated
//  i_cfg_*  | in  | we, no wait         | index 0 skip_count, 1 complex_mode
//
// an item is captured, then one multiplier squares one part at a time and its
// product is added in the following cycle: the real part, then in complex mode the imaginary part
// a last item then loads the root unit, runs the 32 root steps and places the
// root in the output register
// a result waits in the output register; new items are taken meanwhile, and
// only a following last item stalls until the register is free
// synchronous active-low reset clears the sum, the index and both registers

module vector_l2_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    vl2n_in_if.sink                          i_in,
    vl2n_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [vl2n_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [vl2n_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    vl2n_pkg::t_cmd    w_cmd;
    vl2n_pkg::t_status w_status;
    logic              w_in_ready;

    // sequencing
    vl2n_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // arithmetic and storage
    vl2n_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_real_part (i_in.real_part),
        .i_imag_part (i_in.imag_part),
        .i_last      (i_in.last),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_norm      (o_out.norm),
        .o_saturated (o_out.saturated),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

@@ hw/rtl/vl2n_checker.sv @@
// vl2n_checker: port-level assertions for vector_l2_norm, bound to the top level
// depends on vector_l2_norm and its channel interfaces

module vl2n_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_norm,
    input logic        i_saturated
);

    // a result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_norm) && $stable(i_saturated))
        else $error("result item changed while stalled");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while the previous one is in work");

    // a clamped sum has the largest root
    a_sat_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> i_norm == 32'hFFFF_FFFF)
        else $error("saturated result without full-scale norm");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind vector_l2_norm vl2n_checker u_vl2n_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_norm      (o_out.norm),
    .i_saturated (o_out.saturated)
);
